FILE: rtl/core/drive_power_state_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Drive power state sequencer assertion macros
// Concurrent check helpers shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef DRIVE_POWER_STATE_SEQUENCER_DEFINES_SVH
`define DRIVE_POWER_STATE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DPSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DPSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dpss_pkg.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer package
// Codes, state encodings and control word constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dpss_pkg;

    typedef enum logic [1:0] {
        KIND_OP     = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_CTRL   = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_PAUSE = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_RD_STAT = 2'd2,
        ACT_RD_CTRL = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PS_OFF     = 3'd0,
        PS_READY   = 3'd1,
        PS_ON      = 3'd2,
        PS_RUN     = 3'd3,
        PS_QSTOP   = 3'd4,
        PS_FAULT   = 3'd5,
        PS_UNKNOWN = 3'd6
    } t_power_state;

    typedef logic [15:0] t_word;

    localparam logic [7:0] STATUS_MASK  = 8'h6F;
    localparam logic [7:0] ST_OFF_A     = 8'h40;
    localparam logic [7:0] ST_OFF_B     = 8'h60;
    localparam logic [7:0] ST_READY     = 8'h21;
    localparam logic [7:0] ST_ON        = 8'h23;
    localparam logic [7:0] ST_RUN       = 8'h27;
    localparam logic [7:0] ST_QSTOP     = 8'h07;
    localparam logic [7:0] ST_FAULT_A   = 8'h08;
    localparam logic [7:0] ST_FAULT_B   = 8'h28;

    localparam t_word CMD_STOP        = 16'h004D;
    localparam t_word CMD_PAUSE       = 16'h004B;
    localparam t_word MASK_SHUTDOWN   = 16'hFF7E;
    localparam t_word SET_SHUTDOWN    = 16'h0006;
    localparam t_word MASK_DISABLE_V  = 16'hFF7D;
    localparam t_word MASK_SWITCH_ON  = 16'hFF77;
    localparam t_word SET_SWITCH_ON   = 16'h0007;
    localparam t_word MASK_ENABLE_OP  = 16'hFF7F;
    localparam t_word SET_ENABLE_OP   = 16'h000F;
    localparam t_word MASK_QUICK_STOP = 16'hFF7B;
    localparam t_word SET_QUICK_STOP  = 16'h0002;
    localparam t_word SET_FAULT_RST   = 16'h0080;

endpackage

`default_nettype wire

FILE: rtl/core/drive_power_state_sequencer.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer
// Turns operation requests and read-back status/control words into the next
// bus action and control word for a drive power state machine.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one output beat. A beat is captured in an
// input register, decoded combinationally against the held power state and
// requested operation, and lands in the result register. One beat can be
// taken every cycle while the downstream side keeps m_axis_tready high. The
// result register frees as soon as the downstream side takes its beat, so
// s_axis_tready follows m_axis_tready combinationally through that stage.
`default_nettype none

`include "drive_power_state_sequencer_defines.svh"

module drive_power_state_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [1:0] operation, [17:2] word
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] command_word, [18:16] power_state_out
    output logic [1:0]       m_axis_tuser    // [1:0] action
);
    import dpss_pkg::*;

    // input register
    logic         r_in_valid;
    t_kind        r_in_kind;
    t_op          r_in_op;
    t_word        r_in_word;

    // result register
    logic         r_out_valid;
    t_action      r_out_action;
    t_word        r_out_cmd;
    t_power_state r_out_ps;

    // sequencer state
    t_power_state r_power_state;
    t_op          r_req_op;

    t_power_state n_power_state;
    t_op          n_req_op;
    t_action      n_action;
    t_word        n_cmd;

    logic         out_free;
    logic         adv;
    logic         in_fire;

    function automatic logic [7:0] s_byte(input t_word w);
        s_byte = w[7:0];
    endfunction

    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (in_fire) begin
            r_in_kind <= t_kind'(s_axis_tuser);
            r_in_op   <= t_op'(s_axis_tdata[1:0]);
            r_in_word <= s_axis_tdata[17:2];
        end
    end

    always_comb begin
        logic [7:0] st;
        st            = s_byte(r_in_word);
        n_power_state = r_power_state;
        n_req_op      = r_req_op;
        n_action      = ACT_NONE;
        n_cmd         = '0;
        case (r_in_kind)
            KIND_OP: begin
                if (r_in_op != OP_INIT && r_in_op != r_req_op) begin
                    n_req_op = r_in_op;
                    case (r_in_op)
                        OP_STOP: begin
                            n_action = ACT_WRITE;
                            n_cmd    = CMD_STOP;
                        end
                        OP_PAUSE: begin
                            n_action = ACT_WRITE;
                            n_cmd    = CMD_PAUSE;
                        end
                        default: begin
                            n_action = ACT_RD_STAT;
                        end
                    endcase
                end
            end
            KIND_STATUS: begin
                case (st & STATUS_MASK)
                    ST_OFF_A, ST_OFF_B:     n_power_state = PS_OFF;
                    ST_READY:               n_power_state = PS_READY;
                    ST_ON:                  n_power_state = PS_ON;
                    ST_RUN:                 n_power_state = PS_RUN;
                    ST_QSTOP:               n_power_state = PS_QSTOP;
                    ST_FAULT_A, ST_FAULT_B: n_power_state = PS_FAULT;
                    default:                n_power_state = PS_UNKNOWN;
                endcase
                n_action = (n_power_state == PS_UNKNOWN) ? ACT_RD_STAT : ACT_RD_CTRL;
            end
            KIND_CTRL: begin
                case (r_power_state)
                    PS_OFF: begin
                        if (r_req_op == OP_START) begin
                            n_action = ACT_WRITE;
                            n_cmd    = (r_in_word & MASK_SHUTDOWN) | SET_SHUTDOWN;
                        end
                    end
                    PS_READY: begin
                        if (r_req_op == OP_STOP) begin
                            n_action = ACT_WRITE;
                            n_cmd    = r_in_word & MASK_DISABLE_V;
                        end else if (r_req_op == OP_START) begin
                            n_action = ACT_WRITE;
                            n_cmd    = (r_in_word & MASK_SWITCH_ON) | SET_SWITCH_ON;
                        end
                    end
                    PS_ON, PS_QSTOP: begin
                        if (r_req_op == OP_STOP) begin
                            n_action = ACT_WRITE;
                            n_cmd    = r_in_word & MASK_DISABLE_V;
                        end else if (r_req_op == OP_START) begin
                            n_action = ACT_WRITE;
                            n_cmd    = (r_in_word & MASK_ENABLE_OP) | SET_ENABLE_OP;
                        end
                    end
                    PS_RUN: begin
                        if (r_req_op == OP_STOP) begin
                            n_action = ACT_WRITE;
                            n_cmd    = r_in_word & MASK_DISABLE_V;
                        end else if (r_req_op == OP_PAUSE) begin
                            n_action = ACT_WRITE;
                            n_cmd    = (r_in_word & MASK_QUICK_STOP) | SET_QUICK_STOP;
                        end
                    end
                    PS_FAULT: begin
                        n_action = ACT_WRITE;
                        n_cmd    = r_in_word | SET_FAULT_RST;
                    end
                    default: begin
                        n_action = ACT_RD_STAT;
                    end
                endcase
            end
            default: begin
                n_action = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_power_state <= PS_UNKNOWN;
            r_req_op      <= OP_INIT;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (adv) begin
                r_power_state <= n_power_state;
                r_req_op      <= n_req_op;
            end
        end
        if (adv) begin
            r_out_action <= n_action;
            r_out_cmd    <= n_cmd;
            r_out_ps     <= n_power_state;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tdata  = {5'd0, r_out_ps, r_out_cmd};

    // checks
    `DPSS_ASSERT_SAME(a_cmd_zero_unless_write, i_clk, i_rst_n,
        r_out_valid && r_out_action != ACT_WRITE, r_out_cmd == '0,
        "command word set without a write action")
    `DPSS_ASSERT_SAME(a_rd_ctrl_known_state, i_clk, i_rst_n,
        r_out_valid && r_out_action == ACT_RD_CTRL, r_out_ps != PS_UNKNOWN,
        "control word read requested in unknown power state")
    `DPSS_ASSERT_NEXT(a_req_op_sticky, i_clk, i_rst_n,
        r_req_op != OP_INIT, r_req_op != OP_INIT,
        "requested operation fell back to none")
    `DPSS_ASSERT_NEXT(a_ps_only_on_status, i_clk, i_rst_n,
        !(adv && r_in_kind == KIND_STATUS), $stable(r_power_state),
        "power state changed without a status beat")

endmodule

`default_nettype wire
